### hdl/integer_partition_counter_core_assert.svh
// Assertion macros for the integer partition counter core.
`ifndef INTEGER_PARTITION_COUNTER_CORE_ASSERT_SVH
`define INTEGER_PARTITION_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipc assertion failed");
`define IPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipc assertion failed");
`else
`define IPC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IPC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/ipc_pkg.sv
// Shared types, control word encoding and microprogram table.
`default_nettype none
package ipc_pkg;

    localparam int IN_W    = 7;
    localparam int COUNT_W = 32;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_INIT,
        STEP_CLR,
        STEP_JSET,
        STEP_JTEST,
        STEP_RD,
        STEP_WR,
        STEP_JINC,
        STEP_RDN,
        STEP_OUT
    } step_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_I_GT_N,
        COND_J_GT_KMAX,
        COND_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {I_HOLD, I_ONE, I_FROM_J, I_INC} i_op_t;
    typedef enum logic [1:0] {J_HOLD, J_ONE, J_INC} j_op_t;
    typedef enum logic [1:0] {WR_NONE, WR_ONE_AT_ZERO, WR_ZERO_AT_I, WR_SUM_AT_I} wr_t;
    typedef enum logic {RD_I_AND_IJ, RD_N} rd_t;

    typedef struct packed {
        cond_t cond;
        step_t jmp;
        step_t nxt;
        i_op_t i_op;
        j_op_t j_op;
        wr_t   wr;
        rd_t   rd;
        logic  load;
        logic  emit;
        logic  take_in;
    } ipc_ctrl_t;

    typedef struct packed {
        logic i_gt_n;
        logic j_gt_kmax;
        logic out_busy;
    } ipc_stat_t;

    localparam ipc_ctrl_t CTRL_NOP = '{
        cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_IDLE, i_op: I_HOLD, j_op: J_HOLD,
        wr: WR_NONE, rd: RD_I_AND_IJ, load: 1'b0, emit: 1'b0, take_in: 1'b0
    };

    // microprogram: on a true condition jump without action, else act and go to nxt
    function automatic ipc_ctrl_t ucode(input step_t step);
        ipc_ctrl_t c;
        c = CTRL_NOP;
        unique case (step)
            STEP_IDLE: begin
                c.cond = COND_NO_INPUT; c.jmp = STEP_IDLE; c.nxt = STEP_INIT;
                c.load = 1'b1; c.take_in = 1'b1;
            end
            STEP_INIT: begin
                c.nxt = STEP_CLR; c.wr = WR_ONE_AT_ZERO; c.i_op = I_ONE;
            end
            STEP_CLR: begin
                c.cond = COND_I_GT_N; c.jmp = STEP_JSET; c.nxt = STEP_CLR;
                c.wr = WR_ZERO_AT_I; c.i_op = I_INC;
            end
            STEP_JSET: begin
                c.nxt = STEP_JTEST; c.j_op = J_ONE;
            end
            STEP_JTEST: begin
                c.cond = COND_J_GT_KMAX; c.jmp = STEP_RDN; c.nxt = STEP_RD;
                c.i_op = I_FROM_J;
            end
            STEP_RD: begin
                c.cond = COND_I_GT_N; c.jmp = STEP_JINC; c.nxt = STEP_WR;
                c.rd = RD_I_AND_IJ;
            end
            STEP_WR: begin
                c.nxt = STEP_RD; c.wr = WR_SUM_AT_I; c.i_op = I_INC;
            end
            STEP_JINC: begin
                c.nxt = STEP_JTEST; c.j_op = J_INC;
            end
            STEP_RDN: begin
                c.nxt = STEP_OUT; c.rd = RD_N;
            end
            STEP_OUT: begin
                c.cond = COND_OUT_BUSY; c.jmp = STEP_OUT; c.nxt = STEP_IDLE;
                c.rd = RD_N; c.emit = 1'b1;
            end
            default: begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/integer_partition_counter_core.sv
// With n = min(total, MAX_TOTAL) and k = min(largest_part, n), a transaction sets entry 0
// to one, clears entries 1..n, then for j = 1..k adds entry i-j into entry i for i = j..n.
// The single-write RAM port splits each addition into a read step and a write step.
// One item at a time; a new input is taken while a result waits.
// Reset (aresetn, synchronous) returns the sequencer to idle and drops m_valid; the
// count memory is not cleared, since every item rewrites the entries it reads.
`default_nettype none
`include "integer_partition_counter_core_assert.svh"
module integer_partition_counter_core #(
    parameter int MAX_TOTAL = 127
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ipc_pkg::IN_W-1:0]      s_total,
    input  wire logic [ipc_pkg::IN_W-1:0]      s_largest_part,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ipc_pkg::COUNT_W-1:0]   m_count
);
    localparam int IW = $clog2(MAX_TOTAL + 1);

    ipc_pkg::ipc_ctrl_t ctrl;
    ipc_pkg::ipc_stat_t stat;
    logic                        we;
    logic [IW-1:0]               waddr, raddr_a, raddr_b;
    logic [ipc_pkg::COUNT_W-1:0] wdata, rdata_a, rdata_b;

    ipc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .take_in  (s_ready)
    );

    ipc_dp #(.MAX_TOTAL(MAX_TOTAL)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .s_total        (s_total),
        .s_largest_part (s_largest_part),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_count        (m_count),
        .we             (we),
        .waddr          (waddr),
        .wdata          (wdata),
        .raddr_a        (raddr_a),
        .raddr_b        (raddr_b),
        .rdata_a        (rdata_a),
        .rdata_b        (rdata_b)
    );

    ipc_ram #(.WIDTH(ipc_pkg::COUNT_W), .DEPTH(MAX_TOTAL + 1)) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    `IPC_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `IPC_ASSERT_IMP(a_result_from_run, aclk, aresetn, $rose(m_valid), !$past(s_ready))
    `IPC_ASSERT_NXT(a_emit_shows_valid, aclk, aresetn, ctrl.emit, m_valid)
endmodule
`default_nettype wire

### hdl/ipc_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module ipc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

### hdl/ipc_seq.sv
// Microcode sequencer: step counter, control store lookup, conditional jumps.
`default_nettype none
module ipc_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire ipc_pkg::ipc_stat_t   stat,
    output ipc_pkg::ipc_ctrl_t        ctrl,
    output logic                      take_in
);
    ipc_pkg::step_t     step_reg, step_next;
    ipc_pkg::ipc_ctrl_t raw;
    logic               hit;

    always_comb begin
        raw = ipc_pkg::ucode(step_reg);
        unique case (raw.cond)
            ipc_pkg::COND_NEVER:     hit = 1'b0;
            ipc_pkg::COND_NO_INPUT:  hit = ~in_valid;
            ipc_pkg::COND_I_GT_N:    hit = stat.i_gt_n;
            ipc_pkg::COND_J_GT_KMAX: hit = stat.j_gt_kmax;
            ipc_pkg::COND_OUT_BUSY:  hit = stat.out_busy;
            default:                 hit = 1'b0;
        endcase
        ctrl = raw;
        if (hit) begin
            ctrl.i_op = ipc_pkg::I_HOLD;
            ctrl.j_op = ipc_pkg::J_HOLD;
            ctrl.wr   = ipc_pkg::WR_NONE;
            ctrl.load = 1'b0;
            ctrl.emit = 1'b0;
        end
        step_next = hit ? raw.jmp : raw.nxt;
        take_in   = raw.take_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ipc_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end
endmodule
`default_nettype wire

### hdl/ipc_dp.sv
// Datapath: index counters, operand bounds, adder, memory ports, result register.
`default_nettype none
module ipc_dp #(
    parameter int MAX_TOTAL = 127
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire ipc_pkg::ipc_ctrl_t                     ctrl,
    output ipc_pkg::ipc_stat_t                          stat,
    input  wire logic [ipc_pkg::IN_W-1:0]               s_total,
    input  wire logic [ipc_pkg::IN_W-1:0]               s_largest_part,
    input  wire logic                                   m_ready,
    output logic                                        m_valid,
    output logic      [ipc_pkg::COUNT_W-1:0]            m_count,
    output logic                                        we,
    output logic      [$clog2(MAX_TOTAL+1)-1:0]         waddr,
    output logic      [ipc_pkg::COUNT_W-1:0]            wdata,
    output logic      [$clog2(MAX_TOTAL+1)-1:0]         raddr_a,
    output logic      [$clog2(MAX_TOTAL+1)-1:0]         raddr_b,
    input  wire logic [ipc_pkg::COUNT_W-1:0]            rdata_a,
    input  wire logic [ipc_pkg::COUNT_W-1:0]            rdata_b
);
    localparam int IW = $clog2(MAX_TOTAL + 1);
    localparam int CW = $clog2(MAX_TOTAL + 2);
    localparam int EW = (CW > ipc_pkg::IN_W) ? CW : ipc_pkg::IN_W;

    logic [CW-1:0] n_reg, kmax_reg, i_reg, j_reg;
    logic [CW-1:0] n_next, kmax_next, i_next, j_next, ij;
    logic          kzero_reg, kzero_next;
    logic          m_valid_reg, m_valid_next;
    logic [ipc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [EW-1:0] tot_ext, kp_ext, t_sat, k_sat;

    always_comb begin
        tot_ext = EW'(s_total);
        kp_ext  = EW'(s_largest_part);
        t_sat   = (tot_ext > EW'(MAX_TOTAL)) ? EW'(MAX_TOTAL) : tot_ext;
        k_sat   = (kp_ext > t_sat) ? t_sat : kp_ext;

        n_next     = ctrl.load ? CW'(t_sat) : n_reg;
        kmax_next  = ctrl.load ? CW'(k_sat) : kmax_reg;
        kzero_next = ctrl.load ? (s_largest_part == '0) : kzero_reg;

        unique case (ctrl.i_op)
            ipc_pkg::I_HOLD:   i_next = i_reg;
            ipc_pkg::I_ONE:    i_next = CW'(1);
            ipc_pkg::I_FROM_J: i_next = j_reg;
            ipc_pkg::I_INC:    i_next = i_reg + CW'(1);
            default:           i_next = i_reg;
        endcase
        unique case (ctrl.j_op)
            ipc_pkg::J_HOLD: j_next = j_reg;
            ipc_pkg::J_ONE:  j_next = CW'(1);
            ipc_pkg::J_INC:  j_next = j_reg + CW'(1);
            default:         j_next = j_reg;
        endcase

        ij      = i_reg - j_reg;
        raddr_a = (ctrl.rd == ipc_pkg::RD_N) ? n_reg[IW-1:0] : i_reg[IW-1:0];
        raddr_b = ij[IW-1:0];

        we    = (ctrl.wr != ipc_pkg::WR_NONE);
        waddr = (ctrl.wr == ipc_pkg::WR_ONE_AT_ZERO) ? '0 : i_reg[IW-1:0];
        unique case (ctrl.wr)
            ipc_pkg::WR_ONE_AT_ZERO: wdata = ipc_pkg::COUNT_W'(1);
            ipc_pkg::WR_SUM_AT_I:    wdata = rdata_a + rdata_b;
            default:                 wdata = '0;
        endcase

        count_next   = count_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        if (ctrl.emit) begin
            count_next   = kzero_reg ? '0 : rdata_a;
            m_valid_next = 1'b1;
        end

        stat.i_gt_n    = (i_reg > n_reg);
        stat.j_gt_kmax = (j_reg > kmax_reg);
        stat.out_busy  = m_valid_reg & ~m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        n_reg     <= n_next;
        kmax_reg  <= kmax_next;
        kzero_reg <= kzero_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        count_reg <= count_next;
    end

    assign m_valid = m_valid_reg;
    assign m_count = count_reg;
endmodule
`default_nettype wire

### test/integer_partition_counter_core_tb.sv
// Testbench for integer_partition_counter_core: directed and random counts checked in order.
`timescale 1ns / 100ps
module integer_partition_counter_core_tb;

    localparam int IN_W         = ipc_pkg::IN_W;
    localparam int COUNT_W      = ipc_pkg::COUNT_W;
    localparam int MAX_TOTAL    = 127;
    localparam int RX_LONG_HOLD = 2000;
    localparam int DRAIN_CYCLES = 17000;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 72;

    typedef struct packed {
        logic [IN_W-1:0]    total;
        logic [IN_W-1:0]    largest_part;
        logic               typed;
        logic [COUNT_W-1:0] count;
    } partition_case_t;

    localparam partition_case_t DIRECTED_CASES [0:19] = '{
        '{7'd0,   7'd0,   1'b1, 32'd0},
        '{7'd0,   7'd1,   1'b1, 32'd1},
        '{7'd0,   7'd127, 1'b1, 32'd1},
        '{7'd1,   7'd0,   1'b1, 32'd0},
        '{7'd127, 7'd0,   1'b1, 32'd0},
        '{7'd1,   7'd1,   1'b1, 32'd1},
        '{7'd1,   7'd127, 1'b1, 32'd1},
        '{7'd127, 7'd1,   1'b1, 32'd1},
        '{7'd127, 7'd127, 1'b1, 32'd3913864295},
        '{7'd5,   7'd3,   1'b0, 32'd0},
        '{7'd5,   7'd127, 1'b0, 32'd0},
        '{7'd10,  7'd10,  1'b0, 32'd0},
        '{7'd10,  7'd4,   1'b0, 32'd0},
        '{7'd64,  7'd64,  1'b0, 32'd0},
        '{7'd100, 7'd2,   1'b0, 32'd0},
        '{7'd127, 7'd126, 1'b0, 32'd0},
        '{7'd85,  7'd42,  1'b0, 32'd0},
        '{7'd42,  7'd85,  1'b0, 32'd0},
        '{7'd2,   7'd2,   1'b0, 32'd0},
        '{7'd7,   7'd127, 1'b0, 32'd0}
    };

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [IN_W-1:0]    s_total        = '0;
    logic [IN_W-1:0]    s_largest_part = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [COUNT_W-1:0] m_count;

    logic [COUNT_W-1:0] expected_counts [$];
    int                 fail_count       = 0;
    int                 cycle_count      = 0;
    int                 rx_hold_requests = 0;
    int                 rx_hold_served   = 0;

    integer_partition_counter_core #(
        .MAX_TOTAL(MAX_TOTAL)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_total       (s_total),
        .s_largest_part(s_largest_part),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count       (m_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // partitions of total into parts no larger than largest_part, low 32 bits; zero when largest_part is zero
    function automatic logic [COUNT_W-1:0] partition_count(input logic [IN_W-1:0] total,
                                                           input logic [IN_W-1:0] largest_part);
        logic [63:0] ways [0:MAX_TOTAL];
        int n;
        int kmax;
        n = (total > MAX_TOTAL) ? MAX_TOTAL : int'(total);
        ways[0] = 64'd1;
        for (int i = 1; i <= n; i++) ways[i] = 64'd0;
        kmax = (int'(largest_part) > n) ? n : int'(largest_part);
        for (int j = 1; j <= kmax; j++)
            for (int i = j; i <= n; i++)
                ways[i] = ways[i] + ways[i-j];
        if (largest_part == '0) return '0;
        return ways[n][COUNT_W-1:0];
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_item(input logic [IN_W-1:0] total, input logic [IN_W-1:0] largest_part,
                             input logic typed, input logic [COUNT_W-1:0] typed_count,
                             input int gap);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_total        <= total;
        s_largest_part <= largest_part;
        do @(posedge aclk); while (!s_ready);
        expected_counts.push_back(typed ? typed_count : partition_count(total, largest_part));
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int r;
        logic [IN_W-1:0] t;
        logic [IN_W-1:0] k;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_CASES[i])
            send_item(DIRECTED_CASES[i].total, DIRECTED_CASES[i].largest_part,
                      DIRECTED_CASES[i].typed, DIRECTED_CASES[i].count, sender_gap());
        wait_drained();

        // long result stall while cheap transactions keep coming
        rx_hold_requests++;
        for (int i = 0; i < 8; i++)
            send_item(IN_W'($urandom_range(0, 6)), IN_W'($urandom_range(0, 7)), 1'b0, '0, 0);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75)      t = IN_W'($urandom_range(0, 16));
            else if (r < 95) t = IN_W'($urandom_range(17, 63));
            else             t = IN_W'($urandom_range(64, 127));
            if ($urandom_range(0, 2) == 0) k = IN_W'($urandom_range(0, 127));
            else                           k = IN_W'($urandom_range(0, t));
            send_item(t, k, 1'b0, '0, sender_gap());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("integer_partition_counter_core verification clean");
        else
            $display("integer_partition_counter_core verification failed");
        $finish;
    end

    initial begin : result_sink
        int  left;
        bit  level;
        int  r;
        left  = 0;
        level = 1'b1;
        forever begin
            @(negedge aclk);
            if (rx_hold_served != rx_hold_requests) begin
                rx_hold_served++;
                m_ready <= 1'b0;
                repeat (RX_LONG_HOLD - 1) @(negedge aclk);
                left = 0;
            end else begin
                if (left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) begin
                        level = 1'b1;
                        left  = $urandom_range(1, 40);
                    end else if (r < 85) begin
                        level = 1'b0;
                        left  = $urandom_range(1, 3);
                    end else if (r < 97) begin
                        level = 1'b0;
                        left  = $urandom_range(4, 20);
                    end else begin
                        level = 1'b0;
                        left  = $urandom_range(50, 300);
                    end
                end
                m_ready <= level;
                left--;
            end
        end
    end

    always @(posedge aclk) begin : check_result
        logic [COUNT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                $error("count: transaction with none expected, actual %0d", m_count);
                fail_count++;
            end else begin
                want = expected_counts.pop_front();
                if (m_count !== want) begin
                    $error("count: expected %0d, actual %0d", want, m_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_partition_counter_core verification failed");
            $finish;
        end
    end

endmodule

### integer_partition_counter_core.f
+incdir+hdl
hdl/ipc_pkg.sv
hdl/ipc_ram.sv
hdl/ipc_seq.sv
hdl/ipc_dp.sv
hdl/integer_partition_counter_core.sv
test/integer_partition_counter_core_tb.sv
